### rtl/core/cfd_pkg.sv
// ============================================================================
// cfd_pkg: shared types and constants of the command frame deframer
// Parser phases, command classes, register map, the frame record that
// goes from the parser to the classifier, and the register set struct.
// ============================================================================
package cfd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;
    localparam int unsigned RegIdxW = 2;

    // reset values of the configuration registers
    localparam logic [ByteW-1:0] HeaderReset    = 8'hAA;
    localparam logic [ByteW-1:0] InfoReset      = 8'h01;
    localparam logic [ByteW-1:0] MemoryReset    = 8'h02;
    localparam logic [ByteW-1:0] HeartbeatReset = 8'h03;

    // register indexes (byte address = 4 * index)
    localparam logic [RegIdxW-1:0] RegHeader    = 2'd0;
    localparam logic [RegIdxW-1:0] RegInfo      = 2'd1;
    localparam logic [RegIdxW-1:0] RegMemory    = 2'd2;
    localparam logic [RegIdxW-1:0] RegHeartbeat = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_TYPE,
        PH_STATUS,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    typedef enum logic [2:0] {
        CLS_INFO      = 3'd0,
        CLS_MEMORY    = 3'd1,
        CLS_HEARTBEAT = 3'd2,
        CLS_INVALID   = 3'd3,
        CLS_BADSUM    = 3'd4
    } t_class;

    typedef struct packed {
        logic [ByteW-1:0] frame_type;
        logic [ByteW-1:0] frame_status;
        logic [ByteW-1:0] payload_length;
        logic             checksum_ok;
    } t_frame;

    typedef struct packed {
        logic [ByteW-1:0] header_byte;
        logic [ByteW-1:0] info_code;
        logic [ByteW-1:0] memory_code;
        logic [ByteW-1:0] heartbeat_code;
    } t_cfg;

endpackage

### rtl/core/cfd_front.sv
// ============================================================================
// cfd_front: byte parser
// Hunts for the header, collects length, type, status, payload sum and
// checks the checksum byte; pushes one frame record per completed frame.
// ============================================================================
module cfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [cfd_pkg::ByteW-1:0]    i_rx_byte,
    input  logic                         i_buffer_end,
    input  logic [cfd_pkg::ByteW-1:0]    i_header_byte,
    output logic                         o_push,
    output cfd_pkg::t_frame              o_frame,
    input  logic                         i_push_ready
);

    cfd_pkg::t_phase           r_phase, n_phase;
    logic [cfd_pkg::ByteW-1:0] r_length, n_length;
    logic [cfd_pkg::ByteW-1:0] r_left, n_left;
    logic [cfd_pkg::ByteW-1:0] r_type, n_type;
    logic [cfd_pkg::ByteW-1:0] r_status, n_status;
    logic [cfd_pkg::ByteW-1:0] r_sum, n_sum;
    logic                      take;

    // stall only when the queue is full
    assign o_ready = i_push_ready;
    assign take    = i_valid && i_push_ready;

    assign o_frame.frame_type     = r_type;
    assign o_frame.frame_status   = r_status;
    assign o_frame.payload_length = r_length;
    assign o_frame.checksum_ok    = (~r_sum == i_rx_byte);

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_left   = r_left;
        n_type   = r_type;
        n_status = r_status;
        n_sum    = r_sum;
        o_push   = 1'b0;
        if (take) begin
            unique case (r_phase)
                cfd_pkg::PH_LENGTH: begin
                    n_length = i_rx_byte;
                    n_left   = i_rx_byte;
                    n_sum    = i_rx_byte;
                    n_phase  = cfd_pkg::PH_TYPE;
                end
                cfd_pkg::PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = cfd_pkg::PH_STATUS;
                end
                cfd_pkg::PH_STATUS: begin
                    n_status = i_rx_byte;
                    n_sum    = r_sum + i_rx_byte;
                    n_phase  = (r_left == '0) ? cfd_pkg::PH_CHECK : cfd_pkg::PH_PAYLOAD;
                end
                cfd_pkg::PH_PAYLOAD: begin
                    n_sum  = r_sum + i_rx_byte;
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = cfd_pkg::PH_CHECK;
                    end
                end
                cfd_pkg::PH_CHECK: begin
                    o_push  = 1'b1;
                    n_phase = cfd_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx_byte == i_header_byte) ? cfd_pkg::PH_LENGTH
                                                            : cfd_pkg::PH_HUNT;
                end
            endcase
            // end of receive block drops a partial frame
            if (i_buffer_end && n_phase != cfd_pkg::PH_HUNT) begin
                n_phase = cfd_pkg::PH_HUNT;
                n_left  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cfd_pkg::PH_HUNT;
            r_length <= '0;
            r_left   <= '0;
            r_type   <= '0;
            r_status <= '0;
            r_sum    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_left   <= n_left;
            r_type   <= n_type;
            r_status <= n_status;
            r_sum    <= n_sum;
        end
    end

endmodule

### rtl/core/cfd_queue.sv
// ============================================================================
// cfd_queue: two-entry frame queue
// Decouples the parser from the classifier; takes one push and one pop
// per cycle, but refuses a push while it holds two entries.
// ============================================================================
module cfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfd_pkg::t_frame i_frame,
    output logic            o_push_ready,
    output logic            o_valid,
    output cfd_pkg::t_frame o_frame,
    input  logic            i_pop
);

    cfd_pkg::t_frame r_mem [2];
    logic            r_wr, n_wr;
    logic            r_rd, n_rd;
    logic [1:0]      r_count, n_count;
    logic            do_push, do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_frame      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr ^ do_push;
        n_rd    = r_rd ^ do_pop;
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### rtl/core/cfd_back.sv
// ============================================================================
// cfd_back: command classifier and result register
// Flags a bad checksum, else decodes the frame type against the code
// registers, counts errors and holds the result until the receiver takes it.
// ============================================================================
module cfd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  cfd_pkg::t_frame           i_frame,
    output logic                      o_pop,
    input  cfd_pkg::t_cfg             i_cfg,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cfd_pkg::ByteW-1:0] o_frame_type,
    output logic [cfd_pkg::ByteW-1:0] o_frame_status,
    output logic [cfd_pkg::ByteW-1:0] o_payload_length,
    output logic                      o_checksum_ok,
    output logic [2:0]                o_command_class,
    output logic [cfd_pkg::ByteW-1:0] o_error_total
);

    logic                      r_valid;
    cfd_pkg::t_frame           r_frame;
    cfd_pkg::t_class           r_class, n_class;
    logic [cfd_pkg::ByteW-1:0] r_errors, n_errors;

    assign o_pop = i_valid && (!r_valid || i_ready);

    // a bad checksum wins over all; then info over memory, memory over heartbeat
    always_comb begin
        if (!i_frame.checksum_ok) begin
            n_class = cfd_pkg::CLS_BADSUM;
        end else if (i_frame.frame_type == i_cfg.info_code) begin
            n_class = cfd_pkg::CLS_INFO;
        end else if (i_frame.frame_type == i_cfg.memory_code) begin
            n_class = cfd_pkg::CLS_MEMORY;
        end else if (i_frame.frame_type == i_cfg.heartbeat_code) begin
            n_class = cfd_pkg::CLS_HEARTBEAT;
        end else begin
            n_class = cfd_pkg::CLS_INVALID;
        end
        n_errors = r_errors;
        if (n_class == cfd_pkg::CLS_BADSUM || n_class == cfd_pkg::CLS_INVALID) begin
            n_errors = r_errors + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_errors <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_errors <= n_errors;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
            r_class <= n_class;
        end
    end

    assign o_valid          = r_valid;
    assign o_frame_type     = r_frame.frame_type;
    assign o_frame_status   = r_frame.frame_status;
    assign o_payload_length = r_frame.payload_length;
    assign o_checksum_ok    = r_frame.checksum_ok;
    assign o_command_class  = r_class;
    assign o_error_total    = r_errors;

endmodule

### rtl/core/command_frame_deframer_core.sv
// ============================================================================
// command_frame_deframer_core: command frame parser
// Parses header/length/type/status/payload/checksum byte frames and
// reports one classified result per completed frame.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready): one received byte per transaction,
//   with i_buffer_end marking the last byte of a receive block; a frame
//   still open after that byte is dropped.
//   Output channel (o_valid/i_ready): one transaction per frame, issued
//   for the checksum byte: type, status, length, checksum flag, command
//   class and the running error count.
//   APB port: four 8-bit registers at 0x0 (header), 0x4 (info code),
//   0x8 (memory code), 0xC (heartbeat code); write only while idle.
// Flow:
//   One byte per cycle while o_ready is high. On an accepted checksum
//   byte the parser pushes the frame record into the two-entry queue;
//   the result register loads it from there when the register is empty
//   or its result is being taken.
// Reset (i_rst_n low, synchronous): parser hunts for a header, queue and
//   result register empty, error count zero, registers at defaults.
// Receiver stall: the result register holds; further frames collect in
//   the queue, and when it is full o_ready drops until a slot frees.
// ============================================================================
module command_frame_deframer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cfd_pkg::ByteW-1:0]   i_rx_byte,
    input  logic                        i_buffer_end,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cfd_pkg::ByteW-1:0]   o_frame_type,
    output logic [cfd_pkg::ByteW-1:0]   o_frame_status,
    output logic [cfd_pkg::ByteW-1:0]   o_payload_length,
    output logic                        o_checksum_ok,
    output logic [2:0]                  o_command_class,
    output logic [cfd_pkg::ByteW-1:0]   o_error_total,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfd_pkg::AddrW-1:0]   paddr,
    input  logic [cfd_pkg::DataW-1:0]   pwdata,
    output logic [cfd_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    cfd_pkg::t_cfg                r_cfg;
    logic                         cfg_wr;
    logic [cfd_pkg::RegIdxW-1:0]  reg_idx;
    logic [cfd_pkg::ByteW-1:0]    rd_byte;

    logic                         q_push;
    logic                         q_push_ready;
    cfd_pkg::t_frame              q_in;
    logic                         q_valid;
    cfd_pkg::t_frame              q_out;
    logic                         q_pop;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[cfd_pkg::AddrW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte    <= cfd_pkg::HeaderReset;
            r_cfg.info_code      <= cfd_pkg::InfoReset;
            r_cfg.memory_code    <= cfd_pkg::MemoryReset;
            r_cfg.heartbeat_code <= cfd_pkg::HeartbeatReset;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cfd_pkg::RegHeader:    r_cfg.header_byte    <= pwdata[cfd_pkg::ByteW-1:0];
                cfd_pkg::RegInfo:      r_cfg.info_code      <= pwdata[cfd_pkg::ByteW-1:0];
                cfd_pkg::RegMemory:    r_cfg.memory_code    <= pwdata[cfd_pkg::ByteW-1:0];
                cfd_pkg::RegHeartbeat: r_cfg.heartbeat_code <= pwdata[cfd_pkg::ByteW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cfd_pkg::RegHeader:    rd_byte = r_cfg.header_byte;
            cfd_pkg::RegInfo:      rd_byte = r_cfg.info_code;
            cfd_pkg::RegMemory:    rd_byte = r_cfg.memory_code;
            cfd_pkg::RegHeartbeat: rd_byte = r_cfg.heartbeat_code;
            default:               rd_byte = '0;
        endcase
    end

    assign prdata = {{(cfd_pkg::DataW - cfd_pkg::ByteW){1'b0}}, rd_byte};

    // ---------------- front: byte parser ----------------
    cfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_buffer_end (i_buffer_end),
        .i_header_byte(r_cfg.header_byte),
        .o_push       (q_push),
        .o_frame      (q_in),
        .i_push_ready (q_push_ready)
    );

    // ---------------- frame queue ----------------
    cfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_frame      (q_in),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_frame      (q_out),
        .i_pop        (q_pop)
    );

    // ---------------- back: classifier and result register ----------------
    cfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_frame         (q_out),
        .o_pop           (q_pop),
        .i_cfg           (r_cfg),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_type    (o_frame_type),
        .o_frame_status  (o_frame_status),
        .o_payload_length(o_payload_length),
        .o_checksum_ok   (o_checksum_ok),
        .o_command_class (o_command_class),
        .o_error_total   (o_error_total)
    );

endmodule
